### hw/rtl/rust_comment_string_blanker_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the comment and string blanker
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RUST_COMMENT_STRING_BLANKER_UNIT_MACROS_SVH
`define RUST_COMMENT_STRING_BLANKER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, held off during reset
`define RCSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsb assertion failed");

// Next-cycle implication, held off during reset
`define RCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsb assertion failed");

`else

`define RCSB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCSB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/rcsb_pkg.sv
// ----------------------------------------------------------------------------
// rcsb_pkg
// Shared types, constants and the unit classifier of the blanker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcsb_pkg;

    localparam int MAX_HASHES_DEF = 32;
    localparam int UNIT_WIDTH_DEF = 16;
    localparam int UNIT_BITS      = 16;

    localparam logic [UNIT_BITS-1:0] CH_NL     = 16'h000A;
    localparam logic [UNIT_BITS-1:0] CH_SPACE  = 16'h0020;
    localparam logic [UNIT_BITS-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [UNIT_BITS-1:0] CH_HASH   = 16'h0023;
    localparam logic [UNIT_BITS-1:0] CH_SQUOTE = 16'h0027;
    localparam logic [UNIT_BITS-1:0] CH_STAR   = 16'h002A;
    localparam logic [UNIT_BITS-1:0] CH_SLASH  = 16'h002F;
    localparam logic [UNIT_BITS-1:0] CH_BSLASH = 16'h005C;
    localparam logic [UNIT_BITS-1:0] CH_UNDER  = 16'h005F;
    localparam logic [UNIT_BITS-1:0] CH_LOW_B  = 16'h0062;
    localparam logic [UNIT_BITS-1:0] CH_LOW_R  = 16'h0072;
    localparam logic [UNIT_BITS-1:0] HI_SURR_LO = 16'hD800;
    localparam logic [UNIT_BITS-1:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [UNIT_BITS-1:0] LO_SURR_LO = 16'hDC00;
    localparam logic [UNIT_BITS-1:0] LO_SURR_HI = 16'hDFFF;

    // Role of one code unit as the scanner sees it
    typedef enum logic [3:0] {
        CL_OTHER,
        CL_IDENT,
        CL_R,
        CL_B,
        CL_SLASH,
        CL_STAR,
        CL_DQUOTE,
        CL_SQUOTE,
        CL_BSLASH,
        CL_HASH,
        CL_NL,
        CL_HI_SURR,
        CL_LO_SURR
    } cls_t;

    // One classified unit as it travels from front to back
    typedef struct packed {
        logic [UNIT_BITS-1:0] unit;
        logic                 last;
        cls_t                 cls;
    } entry_t;

    function automatic cls_t classify(input logic [UNIT_BITS-1:0] u);
        cls_t c;
        c = CL_OTHER;
        priority if (u == CH_LOW_R)   c = CL_R;
        else if (u == CH_LOW_B)       c = CL_B;
        else if ((u >= 16'h0061 && u <= 16'h007A) || (u >= 16'h0041 && u <= 16'h005A) ||
                 (u >= 16'h0030 && u <= 16'h0039) || u == CH_UNDER)
            c = CL_IDENT;
        else if (u == CH_SLASH)       c = CL_SLASH;
        else if (u == CH_STAR)        c = CL_STAR;
        else if (u == CH_DQUOTE)      c = CL_DQUOTE;
        else if (u == CH_SQUOTE)      c = CL_SQUOTE;
        else if (u == CH_BSLASH)      c = CL_BSLASH;
        else if (u == CH_HASH)        c = CL_HASH;
        else if (u == CH_NL)          c = CL_NL;
        else if (u >= HI_SURR_LO && u <= HI_SURR_HI) c = CL_HI_SURR;
        else if (u >= LO_SURR_LO && u <= LO_SURR_HI) c = CL_LO_SURR;
        else                          c = CL_OTHER;
        return c;
    endfunction

    function automatic logic is_ident(input cls_t c);
        return (c == CL_IDENT) || (c == CL_R) || (c == CL_B);
    endfunction

endpackage

### hw/rtl/rcsb_front.sv
// ----------------------------------------------------------------------------
// rcsb_front
// Accepts code units, masks and classifies them, and queues them for the
// scanner in a two-entry FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcsb_front #(
    parameter int UNIT_WIDTH = rcsb_pkg::UNIT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rcsb_pkg::UNIT_BITS-1:0]     code_unit,
    input  logic                               last_in,
    output logic                               q_valid,
    input  logic                               q_ready,
    output rcsb_pkg::entry_t                   q_entry
);

    localparam logic [rcsb_pkg::UNIT_BITS-1:0] UnitMask =
        rcsb_pkg::UNIT_BITS'((32'd1 << UNIT_WIDTH) - 32'd1);

    rcsb_pkg::entry_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    rcsb_pkg::entry_t new_entry;

    // Mask the unit and tag its role
    always_comb
    begin
        new_entry.unit = code_unit & UnitMask;
        new_entry.last = last_in;
        new_entry.cls  = rcsb_pkg::classify(code_unit & UnitMask);
    end

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_entry  = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

### hw/rtl/rcsb_back.sv
// ----------------------------------------------------------------------------
// rcsb_back
// Lookahead buffer and scanner: decides each buffered unit, tracks comment
// and literal state, and drives the registered output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rust_comment_string_blanker_unit_macros.svh"

module rcsb_back #(
    parameter int MAX_HASHES = rcsb_pkg::MAX_HASHES_DEF,
    parameter int UNIT_WIDTH = rcsb_pkg::UNIT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  rcsb_pkg::entry_t                q_entry,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rcsb_pkg::UNIT_BITS-1:0]  out_unit,
    output logic                            last_out,
    output logic                            hash_overflow
);

    localparam int BufSize = MAX_HASHES + 3;
    localparam int AW      = $clog2(BufSize);
    localparam int SW      = AW + 1;
    localparam int CW      = $clog2(BufSize + 1);
    localparam int HW      = $clog2(MAX_HASHES + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_HEAD, S_FETCH, S_EVAL, S_GRD, S_GOUT
    } state_t;

    typedef enum logic [2:0] {
        M_NORMAL, M_LINE, M_BLOCK, M_STRING, M_RAW
    } mode_t;

    typedef enum logic [1:0] {
        PC_NONE, PC_SLASH, PC_STAR
    } pair_t;

    typedef enum logic [2:0] {
        K_SLASH, K_B, K_Q1, K_Q2, K_RAW
    } kind_t;

    // Lookahead memory
    logic [UNIT_WIDTH-1:0] buf_unit [BufSize];
    rcsb_pkg::cls_t        buf_cls  [BufSize];
    logic                  mem_we, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [UNIT_WIDTH-1:0] rd_unit_reg;
    rcsb_pkg::cls_t        rd_cls_reg;

    state_t           state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             final_reg, final_next;
    mode_t            mode_reg, mode_next;
    logic             quote_reg, quote_next;
    logic             esc_reg, esc_next;
    logic [7:0]       depth_reg, depth_next;
    pair_t            pc_reg, pc_next;
    logic [HW-1:0]    target_reg, target_next;
    logic [HW-1:0]    seen_reg, seen_next;
    logic             prev_ident_reg, prev_ident_next;
    kind_t            kind_reg, kind_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [HW-1:0]    h_reg, h_next;
    logic             n1hi_reg, n1hi_next;
    logic             present_reg, present_next;
    logic [CW-1:0]    len_reg, len_next;
    logic             blank_reg, blank_next;
    logic             ovf_reg, ovf_next;
    logic             out_valid_reg, out_valid_next;
    logic [rcsb_pkg::UNIT_BITS-1:0] out_unit_reg, out_unit_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             out_free;
    logic             prefix;
    logic [7:0]       depth_dec;
    logic [HW-1:0]    seen_inc;
    logic [HW-1:0]    h_inc;
    logic [rcsb_pkg::UNIT_BITS-1:0] rd_wide;
    logic [rcsb_pkg::UNIT_BITS-1:0] rd_blank;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(BufSize))
        begin
            s = s - SW'(BufSize);
        end
        return s[AW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign prefix    = !prev_ident_reg;
    assign depth_dec = (depth_reg != 8'd0) ? depth_reg - 8'd1 : depth_reg;
    assign seen_inc  = seen_reg + HW'(1);
    assign h_inc     = h_reg + HW'(1);
    assign rd_wide   = rcsb_pkg::UNIT_BITS'(rd_unit_reg);
    assign rd_blank  = (rd_cls_reg == rcsb_pkg::CL_NL) ? rd_wide : rcsb_pkg::CH_SPACE;

    assign q_ready       = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_unit      = out_unit_reg;
    assign last_out      = out_last_reg;
    assign hash_overflow = out_ovf_reg;

    // Scanner next state
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        final_next      = final_reg;
        mode_next       = mode_reg;
        quote_next      = quote_reg;
        esc_next        = esc_reg;
        depth_next      = depth_reg;
        pc_next         = pc_reg;
        target_next     = target_reg;
        seen_next       = seen_reg;
        prev_ident_next = prev_ident_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        h_next          = h_reg;
        n1hi_next       = n1hi_reg;
        present_next    = present_reg;
        len_next        = len_reg;
        blank_next      = blank_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        mem_we          = 1'b0;
        wr_addr         = wrap_add(head_reg, count_reg);
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        unique case (state_reg)
            // Take the next unit into the lookahead buffer
            S_IDLE:
            begin
                if (q_valid)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    final_next = q_entry.last;
                    state_next = S_RUN;
                end
            end

            // Read the front unit, or finish the step
            S_RUN:
            begin
                if (count_reg == '0)
                begin
                    if (final_reg)
                    begin
                        mode_next       = M_NORMAL;
                        quote_next      = 1'b0;
                        esc_next        = 1'b0;
                        depth_next      = 8'd0;
                        pc_next         = PC_NONE;
                        target_next     = '0;
                        seen_next       = '0;
                        prev_ident_next = 1'b0;
                        final_next      = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_HEAD;
                end
            end

            // Decide the front unit
            S_HEAD:
            begin
                if (mode_reg == M_NORMAL)
                begin
                    idx_next   = CW'(1);
                    h_next     = '0;
                    len_next   = CW'(1);
                    blank_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_GRD;
                    priority if (rd_cls_reg == rcsb_pkg::CL_SLASH)
                    begin
                        kind_next  = K_SLASH;
                        state_next = S_FETCH;
                    end
                    else if (rd_cls_reg == rcsb_pkg::CL_DQUOTE)
                    begin
                        mode_next  = M_STRING;
                        quote_next = 1'b0;
                        esc_next   = 1'b0;
                        blank_next = 1'b1;
                    end
                    else if (rd_cls_reg == rcsb_pkg::CL_R && prefix)
                    begin
                        kind_next  = K_RAW;
                        state_next = S_FETCH;
                    end
                    else if (rd_cls_reg == rcsb_pkg::CL_B && prefix)
                    begin
                        kind_next  = K_B;
                        state_next = S_FETCH;
                    end
                    else if (rd_cls_reg == rcsb_pkg::CL_SQUOTE)
                    begin
                        kind_next  = K_Q1;
                        state_next = S_FETCH;
                    end
                end
                else if (mode_reg == M_LINE && rd_cls_reg == rcsb_pkg::CL_NL)
                begin
                    // newline ends the comment and is decided again as text
                    mode_next = M_NORMAL;
                end
                else if (out_free)
                begin
                    unique case (mode_reg)
                        M_BLOCK:
                        begin
                            if (pc_reg == PC_SLASH && rd_cls_reg == rcsb_pkg::CL_STAR)
                            begin
                                if (depth_reg != 8'd255)
                                begin
                                    depth_next = depth_reg + 8'd1;
                                end
                                pc_next = PC_NONE;
                            end
                            else if (pc_reg == PC_STAR && rd_cls_reg == rcsb_pkg::CL_SLASH)
                            begin
                                pc_next    = PC_NONE;
                                depth_next = depth_dec;
                                if (depth_dec == 8'd0)
                                begin
                                    mode_next = M_NORMAL;
                                end
                            end
                            else if (rd_cls_reg == rcsb_pkg::CL_SLASH)
                            begin
                                pc_next = PC_SLASH;
                            end
                            else if (rd_cls_reg == rcsb_pkg::CL_STAR)
                            begin
                                pc_next = PC_STAR;
                            end
                            else
                            begin
                                pc_next = PC_NONE;
                            end
                        end
                        M_STRING:
                        begin
                            if (esc_reg)
                            begin
                                esc_next = 1'b0;
                            end
                            else if (rd_cls_reg == rcsb_pkg::CL_BSLASH)
                            begin
                                esc_next = 1'b1;
                            end
                            else if (rd_cls_reg == (quote_reg ? rcsb_pkg::CL_SQUOTE
                                                              : rcsb_pkg::CL_DQUOTE))
                            begin
                                mode_next = M_NORMAL;
                            end
                        end
                        M_RAW:
                        begin
                            if (rd_cls_reg == rcsb_pkg::CL_DQUOTE)
                            begin
                                esc_next  = 1'b1;
                                seen_next = '0;
                                if (target_reg == '0)
                                begin
                                    mode_next = M_NORMAL;
                                    esc_next  = 1'b0;
                                end
                            end
                            else if (rd_cls_reg == rcsb_pkg::CL_HASH && esc_reg)
                            begin
                                seen_next = seen_inc;
                                if (seen_inc >= target_reg)
                                begin
                                    mode_next = M_NORMAL;
                                    esc_next  = 1'b0;
                                    seen_next = '0;
                                end
                            end
                            else
                            begin
                                esc_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // line comment body
                            mode_next = mode_reg;
                        end
                    endcase
                    out_valid_next  = 1'b1;
                    out_unit_next   = rd_blank;
                    out_last_next   = final_reg && (count_reg == CW'(1));
                    out_ovf_next    = 1'b0;
                    prev_ident_next = rcsb_pkg::is_ident(rd_cls_reg);
                    head_next       = wrap_add(head_reg, CW'(1));
                    count_next      = count_reg - CW'(1);
                    state_next      = S_RUN;
                end
            end

            // Read one lookahead unit, if it has arrived
            S_FETCH:
            begin
                rd_addr      = wrap_add(head_reg, idx_reg);
                present_next = (idx_reg < count_reg);
                rd_en        = (idx_reg < count_reg);
                state_next   = S_EVAL;
            end

            // Judge the lookahead unit
            S_EVAL:
            begin
                len_next   = CW'(1);
                blank_next = 1'b0;
                ovf_next   = 1'b0;
                state_next = S_GRD;
                unique case (kind_reg)
                    K_SLASH:
                    begin
                        if (!present_reg)
                        begin
                            state_next = final_reg ? S_GRD : S_IDLE;
                        end
                        else if (rd_cls_reg == rcsb_pkg::CL_SLASH)
                        begin
                            mode_next  = M_LINE;
                            len_next   = CW'(2);
                            blank_next = 1'b1;
                        end
                        else if (rd_cls_reg == rcsb_pkg::CL_STAR)
                        begin
                            mode_next  = M_BLOCK;
                            depth_next = 8'd1;
                            pc_next    = PC_NONE;
                            len_next   = CW'(2);
                            blank_next = 1'b1;
                        end
                    end
                    K_B:
                    begin
                        if (!present_reg)
                        begin
                            state_next = final_reg ? S_GRD : S_IDLE;
                        end
                        else if (rd_cls_reg == rcsb_pkg::CL_DQUOTE ||
                                 rd_cls_reg == rcsb_pkg::CL_SQUOTE)
                        begin
                            mode_next  = M_STRING;
                            quote_next = (rd_cls_reg == rcsb_pkg::CL_SQUOTE);
                            esc_next   = 1'b0;
                            len_next   = CW'(2);
                            blank_next = 1'b1;
                        end
                        else if (rd_cls_reg == rcsb_pkg::CL_R)
                        begin
                            kind_next  = K_RAW;
                            idx_next   = CW'(2);
                            h_next     = '0;
                            state_next = S_FETCH;
                        end
                    end
                    K_Q1:
                    begin
                        if (present_reg && rd_cls_reg == rcsb_pkg::CL_BSLASH)
                        begin
                            mode_next  = M_STRING;
                            quote_next = 1'b1;
                            esc_next   = 1'b0;
                            blank_next = 1'b1;
                        end
                        else if (count_reg < CW'(3) && !final_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            n1hi_next  = present_reg && (rd_cls_reg == rcsb_pkg::CL_HI_SURR);
                            kind_next  = K_Q2;
                            idx_next   = CW'(2);
                            state_next = S_FETCH;
                        end
                    end
                    K_Q2:
                    begin
                        if (present_reg && (rd_cls_reg == rcsb_pkg::CL_SQUOTE ||
                            (n1hi_reg && rd_cls_reg == rcsb_pkg::CL_LO_SURR)))
                        begin
                            mode_next  = M_STRING;
                            quote_next = 1'b1;
                            esc_next   = 1'b0;
                            blank_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        // raw prefix: count hashes up to the opening quote
                        if (!present_reg)
                        begin
                            state_next = final_reg ? S_GRD : S_IDLE;
                        end
                        else if (rd_cls_reg == rcsb_pkg::CL_HASH)
                        begin
                            if (h_inc > HW'(MAX_HASHES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                h_next     = h_inc;
                                idx_next   = idx_reg + CW'(1);
                                state_next = S_FETCH;
                            end
                        end
                        else if (rd_cls_reg == rcsb_pkg::CL_DQUOTE)
                        begin
                            mode_next   = M_RAW;
                            target_next = h_reg;
                            seen_next   = '0;
                            esc_next    = 1'b0;
                            len_next    = idx_reg + CW'(1);
                            blank_next  = 1'b1;
                        end
                    end
                endcase
            end

            // Read the next unit of a decided group
            S_GRD:
            begin
                rd_en      = 1'b1;
                state_next = S_GOUT;
            end

            // Drop the front unit into the output register
            default:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_unit_next   = blank_reg ? rd_blank : rd_wide;
                    out_last_next   = final_reg && (count_reg == CW'(1));
                    out_ovf_next    = ovf_reg;
                    prev_ident_next = rcsb_pkg::is_ident(rd_cls_reg);
                    head_next       = wrap_add(head_reg, CW'(1));
                    count_next      = count_reg - CW'(1);
                    len_next        = len_reg - CW'(1);
                    state_next      = (len_reg == CW'(1)) ? S_RUN : S_GRD;
                end
            end
        endcase
    end

    // Hold scanner state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            final_reg      <= 1'b0;
            mode_reg       <= M_NORMAL;
            quote_reg      <= 1'b0;
            esc_reg        <= 1'b0;
            depth_reg      <= 8'd0;
            pc_reg         <= PC_NONE;
            target_reg     <= '0;
            seen_reg       <= '0;
            prev_ident_reg <= 1'b0;
            kind_reg       <= K_SLASH;
            idx_reg        <= '0;
            h_reg          <= '0;
            n1hi_reg       <= 1'b0;
            present_reg    <= 1'b0;
            len_reg        <= '0;
            blank_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            final_reg      <= final_next;
            mode_reg       <= mode_next;
            quote_reg      <= quote_next;
            esc_reg        <= esc_next;
            depth_reg      <= depth_next;
            pc_reg         <= pc_next;
            target_reg     <= target_next;
            seen_reg       <= seen_next;
            prev_ident_reg <= prev_ident_next;
            kind_reg       <= kind_next;
            idx_reg        <= idx_next;
            h_reg          <= h_next;
            n1hi_reg       <= n1hi_next;
            present_reg    <= present_next;
            len_reg        <= len_next;
            blank_reg      <= blank_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // Lookahead memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            buf_unit[wr_addr] <= q_entry.unit[UNIT_WIDTH-1:0];
            buf_cls[wr_addr]  <= q_entry.cls;
        end
        if (rd_en)
        begin
            rd_unit_reg <= buf_unit[rd_addr];
            rd_cls_reg  <= buf_cls[rd_addr];
        end
    end

    `RCSB_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(BufSize))
    `RCSB_ASSERT_IMPL(a_depth_text, clk, rst_n, mode_reg == M_NORMAL, depth_reg == 8'd0)
    `RCSB_ASSERT_IMPL(a_raw_seen, clk, rst_n, mode_reg == M_RAW, (seen_reg < target_reg) || (seen_reg == '0))
    `RCSB_ASSERT_NEXT(a_end_clear, clk, rst_n, (state_reg == S_RUN) && (count_reg == '0) && final_reg, (mode_reg == M_NORMAL) && !prev_ident_reg && !final_reg)

endmodule

### hw/rtl/rust_comment_string_blanker_unit.sv
// Blanks comments and literals in a stream of Rust source code units: every
// unit comes back once, in order, as itself or as a space (newlines kept).
// Each accepted unit goes through a two-entry input queue into a lookahead
// buffer of MAX_HASHES+3 entries, and a scanner with one read port on that
// buffer decides it. A plain unit that needs no lookahead is written to the
// buffer, read, decided, read again and registered at the output, and the
// scanner passes its run state before it takes the next unit. A unit inside
// a comment or literal skips the second read. Each further unit a decision
// must inspect (comment openers, quotes, byte and raw prefixes with their
// hash run) adds a fetch and an evaluation step. Units held for lookahead
// are released in a burst once decided. A stalled output holds the scanner.
// last_in drains the buffer and returns the scanner to its reset state.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// rust_comment_string_blanker_unit
// Top level: input queue and classifier, lookahead scanner, output register.
// ----------------------------------------------------------------------------
module rust_comment_string_blanker_unit #(
    parameter int MAX_HASHES = rcsb_pkg::MAX_HASHES_DEF,
    parameter int UNIT_WIDTH = rcsb_pkg::UNIT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rcsb_pkg::UNIT_BITS-1:0]  code_unit,
    input  logic                            last_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rcsb_pkg::UNIT_BITS-1:0]  out_unit,
    output logic                            last_out,
    output logic                            hash_overflow
);

    logic             q_valid;
    logic             q_ready;
    rcsb_pkg::entry_t q_entry;

    // Accept and classify
    rcsb_front #(
        .UNIT_WIDTH (UNIT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_unit (code_unit),
        .last_in   (last_in),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry)
    );

    // Scan and transfer results
    rcsb_back #(
        .MAX_HASHES (MAX_HASHES),
        .UNIT_WIDTH (UNIT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_entry       (q_entry),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_unit      (out_unit),
        .last_out      (last_out),
        .hash_overflow (hash_overflow)
    );

endmodule
